### src/petlor_pkg.sv
// ----------------------------------------------------------------------------
// petlor_pkg
// shared types, widths and codes of the line-of-response indexer
// ----------------------------------------------------------------------------
package petlor_pkg;

  // geometry parameters of the scanner
  localparam int BLOCKS_IN_RING    = 16;
  localparam int CRYSTALS_IN_BLOCK = 8;
  localparam int RING_COUNT        = 8;

  // field and datapath widths
  localparam int POS_W   = 24;              // crystal position, Q15.8
  localparam int SIZE_W  = 23;              // box extent
  localparam int ORG_W   = POS_W + 1;       // doubled position, half-lsb units
  localparam int DIR_W   = POS_W + 1;       // direction component
  localparam int NMAG_W  = ORG_W;           // magnitude of plane offset
  localparam int DMAG_W  = POS_W;           // magnitude of direction component
  localparam int PROD_W  = NMAG_W + DMAG_W;
  localparam int NUM_W   = PROD_W + 2;      // rounded-division numerator
  localparam int DEN_W   = DMAG_W + 1;      // rounded-division denominator
  localparam int QUO_W   = 25;              // quotients at or above 2**QUO_W miss the box
  localparam int HIT_W   = QUO_W + 2;
  localparam int TAG_W   = ORG_W + 2;
  localparam int LOR_W   = 19;
  localparam int FACE_LAT = QUO_W + 4;      // register stages through one face unit
  localparam int FACES    = 6;

  // result codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_SAME_BLOCK = 2'd1;
  localparam logic [1:0] STATUS_MISS       = 2'd2;

  typedef logic [2:0][POS_W-1:0]  hit_t;
  typedef logic [2:0][ORG_W-1:0]  org_t;
  typedef logic [2:0][SIZE_W-1:0] size_t;

  typedef struct packed {
    logic [6:0]              first_number;
    logic [3:0]              first_block;
    logic [2:0]              first_ring;
    logic signed [POS_W-1:0] first_pos_x;
    logic signed [POS_W-1:0] first_pos_y;
    logic signed [POS_W-1:0] first_pos_z;
    logic [6:0]              second_number;
    logic [3:0]              second_block;
    logic [2:0]              second_ring;
    logic signed [POS_W-1:0] second_pos_x;
    logic signed [POS_W-1:0] second_pos_y;
    logic signed [POS_W-1:0] second_pos_z;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LOR_W-1:0] line_idx;
  } out_t;

endpackage

### src/petlor_delay.sv
// ----------------------------------------------------------------------------
// petlor_delay
// fixed-length delay line that advances on enable
// ----------------------------------------------------------------------------
module petlor_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] stage_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) stage_q[i] <= '0;
    end else if (en_i) begin
      stage_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) stage_q[i] <= stage_q[i-1];
    end
  end

  assign q_o = stage_q[DEPTH-1];

endmodule

### src/petlor_div.sv
// ----------------------------------------------------------------------------
// petlor_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module petlor_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 25,
  parameter int QUO_W = 25,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic             ovf_q [QUO_W];
  logic [TAG_W-1:0] tag_q [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             ovf_in;
    logic [TAG_W-1:0] tag_in;
    logic [CMP_W-1:0] shifted;
    logic             take;

    if (j == 0) begin : g_first
      // quotient too wide to matter: flag it, the bits below are then junk
      assign ovf_in = CMP_W'(num_i) >= (CMP_W'(den_i) << QUO_W);
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign ovf_in = ovf_q[j-1];
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    assign shifted = CMP_W'(den_in) << (QUO_W - 1 - j);
    assign take    = CMP_W'(rem_in) >= shifted;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? NUM_W'(CMP_W'(rem_in) - shifted) : rem_in;
        quo_q[j] <= quo_in | (take ? (QUO_W'(1) << (QUO_W - 1 - j)) : '0);
        den_q[j] <= den_in;
        ovf_q[j] <= ovf_in;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];
  assign ovf_o = ovf_q[QUO_W-1];
  assign tag_o = tag_q[QUO_W-1];

endmodule

### src/petlor_face.sv
// ----------------------------------------------------------------------------
// petlor_face
// intersection of the line with one box face plane and inside test
// ----------------------------------------------------------------------------
module petlor_face
  import petlor_pkg::*;
#(
  parameter int   AXIS = 2,
  parameter logic NEG  = 1'b0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  org_t  org_i,
  input  org_t  dir_i,
  input  size_t size_i,
  output logic  valid_o,
  output hit_t  hit_o
);

  localparam int K0 = (AXIS == 0) ? 1 : 0;
  localparam int K1 = (AXIS == 2) ? 1 : 2;

  // plane offset and magnitudes
  logic signed [ORG_W-1:0] s_w;
  logic signed [ORG_W:0]   n0_w;
  logic [ORG_W:0]          n0_abs;
  logic [DIR_W-1:0]        da_abs;
  logic [1:0][DIR_W-1:0]   dk_abs;
  logic [1:0][DIR_W-1:0]   dk_w;
  logic [1:0][ORG_W-1:0]   ok_w;

  logic [NMAG_W-1:0]       n0_mag_q;
  logic                    n0_neg_q;
  logic [DMAG_W-1:0]       da_mag_q;
  logic                    da_neg_q;
  logic                    nz_q;
  logic [1:0][DMAG_W-1:0]  dk_mag_q;
  logic [1:0]              dk_neg_q;
  logic [1:0][ORG_W-1:0]   ok_q;

  always_comb begin
    s_w    = NEG ? -$signed({2'b00, size_i[AXIS]}) : $signed({2'b00, size_i[AXIS]});
    n0_w   = $signed({s_w[ORG_W-1], s_w})
           - $signed({org_i[AXIS][ORG_W-1], org_i[AXIS]});
    n0_abs = n0_w[ORG_W] ? (ORG_W+1)'(-n0_w) : n0_w;
    da_abs = dir_i[AXIS][DIR_W-1] ? DIR_W'(-$signed(dir_i[AXIS])) : dir_i[AXIS];
    dk_w[0] = dir_i[K0];
    dk_w[1] = dir_i[K1];
    ok_w[0] = org_i[K0];
    ok_w[1] = org_i[K1];
    for (int l = 0; l < 2; l++) begin
      dk_abs[l] = dk_w[l][DIR_W-1] ? DIR_W'(-$signed(dk_w[l])) : dk_w[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_mag_q <= n0_abs[NMAG_W-1:0];
      n0_neg_q <= n0_w[ORG_W];
      da_mag_q <= da_abs[DMAG_W-1:0];
      da_neg_q <= dir_i[AXIS][DIR_W-1];
      nz_q     <= (dir_i[AXIS] != '0);
      for (int l = 0; l < 2; l++) begin
        dk_mag_q[l] <= dk_abs[l][DMAG_W-1:0];
        dk_neg_q[l] <= dk_w[l][DIR_W-1];
      end
      ok_q <= ok_w;
    end
  end

  // product stage
  logic [1:0][PROD_W-1:0] prod_q;
  logic [1:0]             neg_q;
  logic [DMAG_W-1:0]      da_mag2_q;
  logic                   nz2_q;
  logic [1:0][ORG_W-1:0]  ok2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        prod_q[l] <= PROD_W'(n0_mag_q) * PROD_W'(dk_mag_q[l]);
        neg_q[l]  <= n0_neg_q ^ dk_neg_q[l] ^ da_neg_q;
      end
      da_mag2_q <= da_mag_q;
      nz2_q     <= nz_q;
      ok2_q     <= ok_q;
    end
  end

  // rounded quotient operands: (2n + d) / 2d
  logic [1:0][NUM_W-1:0] num_q;
  logic [DEN_W-1:0]      den_q;
  logic [1:0][TAG_W-1:0] tag_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= NUM_W'({prod_q[l], 1'b0}) + NUM_W'(da_mag2_q);
        tag_q[l] <= {nz2_q, neg_q[l], ok2_q[l]};
      end
      den_q <= {da_mag2_q, 1'b0};
    end
  end

  logic [1:0][QUO_W-1:0] quo_w;
  logic [1:0]            ovf_w;
  logic [1:0][TAG_W-1:0] tag_w;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    petlor_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (QUO_W),
      .TAG_W (TAG_W)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (num_q[l]),
      .den_i (den_q),
      .tag_i (tag_q[l]),
      .quo_o (quo_w[l]),
      .ovf_o (ovf_w[l]),
      .tag_o (tag_w[l])
    );
  end

  // hit coordinates and inside test
  logic signed [1:0][HIT_W-1:0] hit_w;
  logic [1:0][HIT_W-1:0]        hit_abs;
  logic [1:0]                   in_w;
  logic [1:0][POS_W-1:0]        hit_q;
  logic [1:0]                   in_q;
  logic                         nz3_q;
  size_t                        sz_k;

  always_comb begin
    sz_k[0] = size_i[K0];
    sz_k[1] = size_i[K1];
    sz_k[2] = size_i[AXIS];
    for (int l = 0; l < 2; l++) begin
      hit_w[l] = $signed(HIT_W'($signed(tag_w[l][ORG_W-1:0])))
               + (tag_w[l][ORG_W] ? -$signed(HIT_W'(quo_w[l])) : $signed(HIT_W'(quo_w[l])));
      hit_abs[l] = hit_w[l][HIT_W-1] ? HIT_W'(-hit_w[l]) : hit_w[l];
      in_w[l]    = !ovf_w[l] && (hit_abs[l] <= HIT_W'(sz_k[l]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        hit_q[l] <= hit_w[l][POS_W-1:0];
      end
      in_q  <= in_w;
      nz3_q <= tag_w[0][TAG_W-1];
    end
  end

  always_comb begin
    hit_o       = '0;
    hit_o[AXIS] = s_w[POS_W-1:0];
    hit_o[K0]   = hit_q[0];
    hit_o[K1]   = hit_q[1];
  end

  assign valid_o = nz3_q & in_q[0] & in_q[1];

endmodule

### src/pet_lor_index_with_box_test.sv
// ----------------------------------------------------------------------------
// pet_lor_index_with_box_test
// line-of-response indexer for coincidence pairs with image box test
// ----------------------------------------------------------------------------
// A coincidence pair goes in on the input channel and exactly one result
// comes out per pair, in order. The block takes a new pair every cycle
// unless the output stalls. Between its set-up and hit selection registers
// lie the six face units, each of which runs two 25-stage restoring
// dividers for the plane hit coordinates. The whole pipeline advances as one:
// while the output register holds a result that is not taken, nothing moves
// and in_ready_o is low, so no transaction is lost or repeated. The box size
// registers sit on the APB-style port at 0x0, 0x4 and 0x8 and must only be
// written while no pair is in flight. Status 1 means the two crystals share a
// block, status 2 that the line misses the box, and the index is zero then.
// ----------------------------------------------------------------------------
module pet_lor_index_with_box_test
  import petlor_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // pair input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // register map indexes
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(25600);

  // index packing constants
  localparam int PAIRS = (BLOCKS_IN_RING * (BLOCKS_IN_RING - 1) / 2)
                         * CRYSTALS_IN_BLOCK * CRYSTALS_IN_BLOCK;
  localparam logic [LOR_W-1:0] NB_L    = LOR_W'(BLOCKS_IN_RING);
  localparam logic [LOR_W-1:0] CIB_L   = LOR_W'(CRYSTALS_IN_BLOCK);
  localparam logic [LOR_W-1:0] RC_L    = LOR_W'(RING_COUNT);
  localparam logic [LOR_W-1:0] PAIRS_L = LOR_W'(PAIRS);

  // ---------------------------------------------------------------- config
  size_t size_q;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= {SIZE_RESET, SIZE_RESET, SIZE_RESET};
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SIZE_X: size_q[0] <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y: size_q[1] <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z: size_q[2] <= pwdata[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SIZE_X: prdata = 32'(size_q[0]);
      REG_SIZE_Y: prdata = 32'(size_q[1]);
      REG_SIZE_Z: prdata = 32'(size_q[2]);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------- flow control
  // one enable for every stage: hold everything while the result waits
  logic out_v_q;
  logic en;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  // ----------------------------------------------------------- entry stage
  in_t  in_q;
  logic v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) in_q <= in_data_i;
  end

  // ------------------------------------------- ordering and line set-up
  // crystal offset in its block by conditional subtraction
  function automatic logic [6:0] crystal_offset(input logic [6:0] c);
    logic [13:0] r;
    r = {7'd0, c};
    for (int j = 6; j >= 0; j--) begin
      if (r >= (14'(CRYSTALS_IN_BLOCK) << j)) r = r - (14'(CRYSTALS_IN_BLOCK) << j);
    end
    return r[6:0];
  endfunction

  logic       lo_first;
  org_t       org_w, dir_w;
  logic [POS_W-1:0] p_w [3];
  logic [POS_W-1:0] q_w [3];

  org_t       org_q, dir_q;
  logic [6:0] c1_q, c2_q;
  logic [3:0] b1_q, b2_q;
  logic [2:0] r1_q, r2_q;
  logic       v1_q;

  always_comb begin
    // equal numbers put the second crystal first
    lo_first = in_q.first_number < in_q.second_number;
    p_w[0] = in_q.first_pos_x;
    p_w[1] = in_q.first_pos_y;
    p_w[2] = in_q.first_pos_z;
    q_w[0] = in_q.second_pos_x;
    q_w[1] = in_q.second_pos_y;
    q_w[2] = in_q.second_pos_z;
    for (int k = 0; k < 3; k++) begin
      org_w[k] = {p_w[k], 1'b0};
      dir_w[k] = ORG_W'($signed({q_w[k][POS_W-1], q_w[k]})
                      - $signed({p_w[k][POS_W-1], p_w[k]}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      org_q <= org_w;
      dir_q <= dir_w;
      if (lo_first) begin
        c1_q <= crystal_offset(in_q.first_number);
        b1_q <= in_q.first_block;
        r1_q <= in_q.first_ring;
        c2_q <= crystal_offset(in_q.second_number);
        b2_q <= in_q.second_block;
        r2_q <= in_q.second_ring;
      end else begin
        c1_q <= crystal_offset(in_q.second_number);
        b1_q <= in_q.second_block;
        r1_q <= in_q.second_ring;
        c2_q <= crystal_offset(in_q.first_number);
        b2_q <= in_q.first_block;
        r2_q <= in_q.first_ring;
      end
    end
  end

  // --------------------------------------------------------- index packing
  // wraps in LOR_W bits, which matches the kept low bits of the full sum
  logic [8:0]       tri_sum;
  logic [LOR_W-1:0] pair_off, in_pair, lor_w;
  logic             same_blk;

  always_comb begin
    tri_sum  = 9'(b1_q) * (9'(b1_q) + 9'd3);
    pair_off = LOR_W'(b2_q) - LOR_W'(1) + NB_L * LOR_W'(b1_q) - LOR_W'(tri_sum >> 1);
    in_pair  = pair_off * CIB_L * CIB_L + LOR_W'(c1_q) * CIB_L + LOR_W'(c2_q);
    lor_w    = (LOR_W'(r1_q) * RC_L + LOR_W'(r2_q)) * PAIRS_L + in_pair;
    same_blk = (b1_q == b2_q);
  end

  // side band travels alongside the face units
  logic [LOR_W+1:0] side_w, side_q;

  assign side_w = {v1_q, same_blk, lor_w};

  petlor_delay #(
    .WIDTH (LOR_W + 2),
    .DEPTH (FACE_LAT)
  ) u_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (side_w),
    .q_o    (side_q)
  );

  // ------------------------------------------------------------ face units
  // order +z, -z, +y, -y, +x, -x
  logic [FACES-1:0] fvalid;
  hit_t             fhit [FACES];

  for (genvar f = 0; f < FACES; f++) begin : g_face
    petlor_face #(
      .AXIS (2 - f / 2),
      .NEG  (1'(f % 2))
    ) u_face (
      .clk_i   (clk_i),
      .en_i    (en),
      .org_i   (org_q),
      .dir_i   (dir_q),
      .size_i  (size_q),
      .valid_o (fvalid[f]),
      .hit_o   (fhit[f])
    );
  end

  // ------------------------------------------- first kept hit selection
  logic [FACES-1:0] rest_w, rest_q;
  hit_t             first_w, first_q;
  hit_t             hits_q [FACES];
  logic             found;
  logic             pv_q, psb_q;
  logic [LOR_W-1:0] plor_q;

  always_comb begin
    found   = 1'b0;
    first_w = '0;
    rest_w  = '0;
    for (int f = 0; f < FACES; f++) begin
      if (fvalid[f]) begin
        if (!found) begin
          first_w = fhit[f];
          found   = 1'b1;
        end else begin
          rest_w[f] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= side_q[LOR_W+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rest_q  <= rest_w;
      first_q <= first_w;
      hits_q  <= fhit;
      psb_q   <= side_q[LOR_W];
      plor_q  <= side_q[LOR_W-1:0];
    end
  end

  // ------------------------------------------------------- result stage
  logic accept;
  out_t res_w, out_q;

  always_comb begin
    accept = 1'b0;
    for (int f = 0; f < FACES; f++) begin
      if (rest_q[f] && (hits_q[f] != first_q)) accept = 1'b1;
    end
    priority if (psb_q) begin
      res_w.status   = STATUS_SAME_BLOCK;
      res_w.line_idx = '0;
    end else if (accept) begin
      res_w.status   = STATUS_OK;
      res_w.line_idx = plor_q;
    end else begin
      res_w.status   = STATUS_MISS;
      res_w.line_idx = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= res_w;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### src/petlor_checker.sv
// ----------------------------------------------------------------------------
// petlor_checker
// port-level checks of the line-of-response indexer
// ----------------------------------------------------------------------------
module petlor_checker
  import petlor_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o,
  input logic pready
);

  // a result never carries the unused status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_OK ||
                     out_data_o.status == STATUS_SAME_BLOCK ||
                     out_data_o.status == STATUS_MISS))
    else $error("undefined status code");

  // rejected pairs carry a zero index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != STATUS_OK) |-> out_data_o.line_idx == '0)
    else $error("nonzero index on rejected pair");

  // input only stalls behind an untaken result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // a waiting result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped or changed while stalled");

  // the configuration port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind pet_lor_index_with_box_test petlor_checker u_petlor_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);
